// File: design/fractional_knapsack_greedy_core_assert.svh
// Assertion macros for the fractional knapsack core checker.
// Included by the checker file; no other dependencies.
`ifndef FRACTIONAL_KNAPSACK_GREEDY_CORE_ASSERT_SVH
`define FRACTIONAL_KNAPSACK_GREEDY_CORE_ASSERT_SVH

// check a property while out of reset
`define FKG_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// check a property at every edge, reset included
`define FKG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/fkg_pkg.sv
// Shared types and constants for the fractional knapsack core.
// No dependencies.
package fkg_pkg;

    localparam int unsigned CAP_W   = 22;
    localparam int unsigned NUM_W   = 48;
    localparam int unsigned TOTAL_W = 38;

    typedef struct packed {
        logic [15:0] item_value;
        logic [15:0] item_weight;
        logic        last_item;
    } item_t;

    typedef struct packed {
        logic [6:0]  item_id;
        logic [16:0] fraction_q16;
        logic [31:0] gained_q16;
        logic [21:0] remaining_capacity;
        logic [37:0] total_q16;
        logic        taken;
        logic        status;
        logic        last_result;
    } result_t;

    typedef struct packed {
        logic [15:0] value;
        logic [15:0] weight;
        logic        last;
        logic        keep;
        logic        zero;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } queue_head_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STORE,
        ST_WAIT_O,
        ST_WAIT_VW,
        ST_CMP,
        ST_PLACE,
        ST_FSTART,
        ST_FCHK,
        ST_FWAIT_O,
        ST_FWAIT_VW,
        ST_FEVAL,
        ST_DFRAC,
        ST_DGAIN,
        ST_DONE
    } back_state_t;

endpackage

// File: design/fkg_front.sv
// Front end: accepts items and classifies them (kept, dropped, zero weight).
// Depends on fkg_pkg.
module fkg_front #(
    parameter int MAX_ITEMS = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           full,
    input  fkg_pkg::item_t item,
    output logic           push,
    output fkg_pkg::entry_t push_entry
);
    localparam int CW = $clog2(MAX_ITEMS + 1);

    logic [CW-1:0] set_cnt_reg;
    logic [CW-1:0] set_cnt_next;
    logic          keep;

    assign push = start && !full;
    assign keep = (set_cnt_reg < CW'(MAX_ITEMS));

    always_comb
    begin
        push_entry.value  = item.item_value;
        push_entry.weight = item.item_weight;
        push_entry.last   = item.last_item;
        push_entry.keep   = keep;
        push_entry.zero   = keep && (item.item_weight == 16'd0);
        set_cnt_next = set_cnt_reg;
        if (push)
        begin
            if (item.last_item)
                set_cnt_next = '0;
            else if (keep)
                set_cnt_next = set_cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            set_cnt_reg <= '0;
        else
            set_cnt_reg <= set_cnt_next;
    end
endmodule

// File: design/fkg_queue.sv
// Two-entry item queue between front and back end.
// Depends on fkg_pkg.
module fkg_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  fkg_pkg::entry_t       push_entry,
    input  logic                  pop,
    output logic                  full,
    output fkg_pkg::queue_head_t  head
);
    fkg_pkg::entry_t slots_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;

    assign full       = (fill_reg == 2'd2);
    assign head.valid = (fill_reg != 2'd0);
    assign head.entry = slots_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
            fill_next = fill_reg + 2'd1;
        else if (pop && !push)
            fill_next = fill_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_entry;
    end
endmodule

// File: design/fkg_div.sv
// Serial restoring divider, one quotient bit per cycle.
// Depends on fkg_pkg.
module fkg_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [fkg_pkg::NUM_W-1:0]   num,
    input  logic [15:0]                 den,
    output logic                        done,
    output logic [fkg_pkg::NUM_W-1:0]   quot
);
    localparam int NW  = fkg_pkg::NUM_W;
    localparam int CTW = $clog2(NW);

    logic           busy_reg;
    logic           done_reg;
    logic [CTW-1:0] cnt_reg;
    logic [NW-1:0]  num_reg;
    logic [NW-1:0]  quot_reg;
    logic [15:0]    rem_reg;
    logic [15:0]    den_reg;
    logic [16:0]    shifted;
    logic [16:0]    diff;
    logic           ge;

    assign shifted = {rem_reg, num_reg[NW-1]};
    assign ge      = (shifted >= {1'b0, den_reg});
    assign diff    = shifted - {1'b0, den_reg};
    assign done    = done_reg;
    assign quot    = quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CTW'(1);
                if (cnt_reg == CTW'(NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= num;
            den_reg  <= den;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg  <= {num_reg[NW-2:0], 1'b0};
            quot_reg <= {quot_reg[NW-2:0], ge};
            rem_reg  <= ge ? diff[15:0] : shifted[15:0];
        end
    end
endmodule

// File: design/fkg_back.sv
// Back end: sorted insertion by value per weight and the greedy fill.
// Depends on fkg_pkg and fkg_div.
module fkg_back #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fkg_pkg::queue_head_t         head,
    output logic                         pop,
    input  logic [fkg_pkg::CAP_W-1:0]    capacity,
    output logic                         result_valid,
    output fkg_pkg::result_t             result
);
    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int KW = fkg_pkg::CAP_W;
    localparam int TW = fkg_pkg::TOTAL_W;
    localparam int NW = fkg_pkg::NUM_W;

    logic [15:0]   value_mem  [MAX_ITEMS];
    logic [15:0]   weight_mem [MAX_ITEMS];
    logic [AW-1:0] order_mem  [MAX_ITEMS];

    fkg_pkg::back_state_t state_reg, state_next;
    fkg_pkg::entry_t      cur_reg, cur_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            zero_reg, zero_next;
    logic [CW-1:0]   pos_reg, pos_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic [AW-1:0]   o_reg, o_next;
    logic [15:0]     v_reg, v_next;
    logic [15:0]     w_reg, w_next;
    logic [31:0]     lhs_reg, lhs_next;
    logic [31:0]     rhs_reg, rhs_next;
    logic [31:0]     prod_reg, prod_next;
    logic [16:0]     frac_reg, frac_next;
    logic [KW-1:0]   rem_reg, rem_next;
    logic [TW-1:0]   total_reg, total_next;
    logic            any_reg, any_next;
    logic            rv_reg, rv_next;
    fkg_pkg::result_t res_reg, res_next;

    logic [AW-1:0]   ord_addr;
    logic [AW-1:0]   vw_addr;
    logic [AW-1:0]   ord_rd_reg;
    logic [15:0]     val_rd_reg;
    logic [15:0]     wgt_rd_reg;
    logic            vw_we;
    logic            ord_we;
    logic [AW-1:0]   ord_wa;
    logic [AW-1:0]   ord_wd;
    logic            div_start;
    logic [NW-1:0]   div_num;
    logic            div_done;
    logic [NW-1:0]   div_quot;
    logic [KW-1:0]   rem_after;
    logic [31:0]     gain_whole;

    fkg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (w_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign result_valid = rv_reg;
    assign result       = res_reg;
    assign rem_after    = rem_reg - {{(KW-16){1'b0}}, w_reg};
    assign gain_whole   = {v_reg, 16'd0};

    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        count_next = count_reg;
        zero_next  = zero_reg;
        pos_next   = pos_reg;
        idx_next   = idx_reg;
        o_next     = o_reg;
        v_next     = v_reg;
        w_next     = w_reg;
        lhs_next   = lhs_reg;
        rhs_next   = rhs_reg;
        prod_next  = prod_reg;
        frac_next  = frac_reg;
        rem_next   = rem_reg;
        total_next = total_reg;
        any_next   = any_reg;
        rv_next    = 1'b0;
        res_next   = res_reg;
        pop        = 1'b0;
        ord_addr   = '0;
        vw_addr    = '0;
        vw_we      = 1'b0;
        ord_we     = 1'b0;
        ord_wa     = pos_reg[AW-1:0];
        ord_wd     = o_reg;
        div_start  = 1'b0;
        div_num    = {{(NW-32){1'b0}}, rem_reg[15:0], 16'd0};

        case (state_reg)
            fkg_pkg::ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop      = 1'b1;
                    cur_next = head.entry;
                    if (head.entry.keep)
                        state_next = fkg_pkg::ST_STORE;
                    else if (head.entry.last)
                        state_next = fkg_pkg::ST_FSTART;
                end
            end
            fkg_pkg::ST_STORE:
            begin
                vw_we     = 1'b1;
                pos_next  = count_reg;
                zero_next = zero_reg | cur_reg.zero;
                ord_addr  = AW'(count_reg - CW'(1));
                if (count_reg == '0)
                    state_next = fkg_pkg::ST_PLACE;
                else
                    state_next = fkg_pkg::ST_WAIT_O;
            end
            fkg_pkg::ST_WAIT_O:
            begin
                vw_addr    = ord_rd_reg;
                o_next     = ord_rd_reg;
                state_next = fkg_pkg::ST_WAIT_VW;
            end
            fkg_pkg::ST_WAIT_VW:
            begin
                lhs_next   = cur_reg.value * wgt_rd_reg;
                rhs_next   = val_rd_reg * cur_reg.weight;
                state_next = fkg_pkg::ST_CMP;
            end
            fkg_pkg::ST_CMP:
            begin
                if (lhs_reg <= rhs_reg)
                    state_next = fkg_pkg::ST_PLACE;
                else
                begin
                    ord_we   = 1'b1;
                    pos_next = pos_reg - CW'(1);
                    ord_addr = AW'(pos_reg - CW'(2));
                    if (pos_reg == CW'(1))
                        state_next = fkg_pkg::ST_PLACE;
                    else
                        state_next = fkg_pkg::ST_WAIT_O;
                end
            end
            fkg_pkg::ST_PLACE:
            begin
                ord_we     = 1'b1;
                ord_wd     = count_reg[AW-1:0];
                count_next = count_reg + CW'(1);
                if (cur_reg.last)
                    state_next = fkg_pkg::ST_FSTART;
                else
                    state_next = fkg_pkg::ST_IDLE;
            end
            fkg_pkg::ST_FSTART:
            begin
                rem_next   = capacity;
                total_next = '0;
                idx_next   = '0;
                any_next   = 1'b0;
                if (zero_reg)
                begin
                    rv_next              = 1'b1;
                    res_next             = '0;
                    res_next.status      = 1'b1;
                    res_next.last_result = 1'b1;
                    state_next           = fkg_pkg::ST_DONE;
                end
                else
                    state_next = fkg_pkg::ST_FCHK;
            end
            fkg_pkg::ST_FCHK:
            begin
                ord_addr = idx_reg[AW-1:0];
                if (idx_reg == count_reg || rem_reg == '0)
                begin
                    if (!any_reg)
                    begin
                        rv_next                     = 1'b1;
                        res_next                    = '0;
                        res_next.remaining_capacity = rem_reg;
                        res_next.last_result        = 1'b1;
                    end
                    state_next = fkg_pkg::ST_DONE;
                end
                else
                    state_next = fkg_pkg::ST_FWAIT_O;
            end
            fkg_pkg::ST_FWAIT_O:
            begin
                vw_addr    = ord_rd_reg;
                o_next     = ord_rd_reg;
                state_next = fkg_pkg::ST_FWAIT_VW;
            end
            fkg_pkg::ST_FWAIT_VW:
            begin
                v_next     = val_rd_reg;
                w_next     = wgt_rd_reg;
                state_next = fkg_pkg::ST_FEVAL;
            end
            fkg_pkg::ST_FEVAL:
            begin
                any_next = 1'b1;
                if ({{(KW-16){1'b0}}, w_reg} <= rem_reg)
                begin
                    rem_next   = rem_after;
                    total_next = total_reg + TW'(gain_whole);
                    idx_next   = idx_reg + CW'(1);
                    rv_next                     = 1'b1;
                    res_next.item_id            = 7'(o_reg) + 7'd1;
                    res_next.fraction_q16       = 17'h10000;
                    res_next.gained_q16         = gain_whole;
                    res_next.remaining_capacity = rem_after;
                    res_next.total_q16          = total_reg + TW'(gain_whole);
                    res_next.taken              = 1'b1;
                    res_next.status             = 1'b0;
                    res_next.last_result        = (rem_after == '0) ||
                                                  (idx_reg + CW'(1) == count_reg);
                    state_next = fkg_pkg::ST_FCHK;
                end
                else
                begin
                    div_start  = 1'b1;
                    prod_next  = v_reg * rem_reg[15:0];
                    state_next = fkg_pkg::ST_DFRAC;
                end
            end
            fkg_pkg::ST_DFRAC:
            begin
                if (div_done)
                begin
                    frac_next  = div_quot[16:0];
                    div_start  = 1'b1;
                    div_num    = {prod_reg, 16'd0};
                    state_next = fkg_pkg::ST_DGAIN;
                end
            end
            fkg_pkg::ST_DGAIN:
            begin
                if (div_done)
                begin
                    rem_next   = '0;
                    total_next = total_reg + TW'(div_quot[31:0]);
                    rv_next                     = 1'b1;
                    res_next.item_id            = 7'(o_reg) + 7'd1;
                    res_next.fraction_q16       = frac_reg;
                    res_next.gained_q16         = div_quot[31:0];
                    res_next.remaining_capacity = '0;
                    res_next.total_q16          = total_reg + TW'(div_quot[31:0]);
                    res_next.taken              = 1'b1;
                    res_next.status             = 1'b0;
                    res_next.last_result        = 1'b1;
                    state_next = fkg_pkg::ST_DONE;
                end
            end
            fkg_pkg::ST_DONE:
            begin
                count_next = '0;
                zero_next  = 1'b0;
                state_next = fkg_pkg::ST_IDLE;
            end
            default:
                state_next = fkg_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fkg_pkg::ST_IDLE;
            count_reg <= '0;
            zero_reg  <= 1'b0;
            rv_reg    <= 1'b0;
            rem_reg   <= '0;
            total_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            zero_reg  <= zero_next;
            rv_reg    <= rv_next;
            rem_reg   <= rem_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        pos_reg  <= pos_next;
        idx_reg  <= idx_next;
        o_reg    <= o_next;
        v_reg    <= v_next;
        w_reg    <= w_next;
        lhs_reg  <= lhs_next;
        rhs_reg  <= rhs_next;
        prod_reg <= prod_next;
        frac_reg <= frac_next;
        any_reg  <= any_next;
        res_reg  <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (vw_we)
        begin
            value_mem[count_reg[AW-1:0]]  <= cur_reg.value;
            weight_mem[count_reg[AW-1:0]] <= cur_reg.weight;
        end
        val_rd_reg <= value_mem[vw_addr];
        wgt_rd_reg <= weight_mem[vw_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ord_we)
            order_mem[ord_wa] <= ord_wd;
        ord_rd_reg <= order_mem[ord_addr];
    end
endmodule

// File: design/fractional_knapsack_greedy_core.sv
// Top level of the fractional knapsack core: capacity register, front, queue, back.
// Depends on fkg_pkg, fkg_front, fkg_queue, fkg_back.
//
// Items are taken whenever busy is low; a two-entry queue holds them while the
// back end works. Storing an item writes it and then compares it with stored
// items in the insertion walk over the order memory; this walk sets the load
// rate. The fill after the last item reads each whole item taken in turn, and
// a partial item takes two passes of the serial divider.
// Results come out one cycle each on result with result_valid high and cannot
// be held off.
module fractional_knapsack_greedy_core #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  fkg_pkg::item_t             item,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [fkg_pkg::CAP_W-1:0]  cfg_data,
    output logic                       result_valid,
    output fkg_pkg::result_t           result
);
    logic [fkg_pkg::CAP_W-1:0] capacity_reg;
    logic                      push;
    logic                      pop;
    logic                      full;
    fkg_pkg::entry_t           push_entry;
    fkg_pkg::queue_head_t      head;

    assign busy      = full;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            capacity_reg <= '0;
        else if (cfg_valid && cfg_ready)
            capacity_reg <= cfg_data;
    end

    fkg_front #(.MAX_ITEMS(MAX_ITEMS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .full       (full),
        .item       (item),
        .push       (push),
        .push_entry (push_entry)
    );

    fkg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .head       (head)
    );

    fkg_back #(.MAX_ITEMS(MAX_ITEMS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .capacity     (capacity_reg),
        .result_valid (result_valid),
        .result       (result)
    );
endmodule

// File: design/fkg_checker.sv
// Port-level checker for the fractional knapsack core, bound to the top level.
// Depends on fkg_pkg and fractional_knapsack_greedy_core_assert.svh.
`include "fractional_knapsack_greedy_core_assert.svh"

module fkg_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             busy,
    input logic             result_valid,
    input fkg_pkg::result_t result
);
    `FKG_ASSERT(a_err_single, clk, rst_n, result_valid && result.status |-> result.last_result && !result.taken && result.total_q16 == 38'd0, "error result malformed")
    `FKG_ASSERT(a_empty_last, clk, rst_n, result_valid && !result.taken |-> result.last_result, "untaken result not final")
    `FKG_ASSERT(a_taken_ids, clk, rst_n, result_valid && result.taken |-> result.item_id != 7'd0 && result.fraction_q16 != 17'd0, "taken result lacks id or fraction")
    `FKG_ASSERT_ALWAYS(a_reset_free, clk, !rst_n |=> !busy, "busy right after reset")
endmodule

bind fractional_knapsack_greedy_core fkg_checker u_fkg_checker (.*);
